### rtl/modulus_encoder_six_digit_top_assert.svh
// Assertion macros for the modulus encoder.
`ifndef MODULUS_ENCODER_SIX_DIGIT_TOP_ASSERT_SVH
`define MODULUS_ENCODER_SIX_DIGIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MES6_ASSERT_IMP(label, clock, rstn, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (!rstn) (lhs) |-> (rhs)) \
    else $error("modulus encoder assertion failed");

`define MES6_ASSERT_NXT(label, clock, rstn, lhs, rhs) \
  label: assert property (@(posedge clock) disable iff (!rstn) (lhs) |=> (rhs)) \
    else $error("modulus encoder assertion failed");

`else

`define MES6_ASSERT_IMP(label, clock, rstn, lhs, rhs)

`define MES6_ASSERT_NXT(label, clock, rstn, lhs, rhs)

`endif

`endif

### rtl/mes6_pkg.sv
`timescale 1ns / 1ps

package mes6_pkg;

  localparam int NUM_MODULI             = 5;
  localparam int DIGIT_W                = 8;
  localparam int MOD_W                  = 9;
  localparam int COUNT_W                = 6;
  localparam int STEP_BITS              = 8;
  localparam int DIGIT5_W               = 32;
  localparam int DEFAULT_MAX_FRAME_BITS = 63;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_0 = 3'd1;

  localparam logic [MOD_W-1:0] MOD_MIN = 9'd1;
  localparam logic [MOD_W-1:0] MOD_MAX = 9'd256;

  typedef logic [NUM_MODULI-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                  bit_count;
    logic [NUM_MODULI-1:0][MOD_W-1:0]    moduli;
  } cfg_t;

  function automatic logic [MOD_W-1:0] clamp_modulus(input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] res;
    res = m;
    if (m == '0) begin
      res = MOD_MIN;
    end else if (m > MOD_MAX) begin
      res = MOD_MAX;
    end
    return res;
  endfunction

endpackage

### rtl/modulus_encoder_six_digit_top.sv
`timescale 1ns / 1ps
// Mixed-radix encoder: a frame of up to MAX_FRAME_BITS bits, masked to the configured bit
// count, is split by five moduli into five remainders and a final quotient. The datapath is
// a chain of 5 * ceil(MAX_FRAME_BITS / 8) division cells (40 at the default), each resolving
// eight quotient bits with a 9-bit compare and subtract; a new word is accepted every cycle
// while in_stall is low. Empty cells are filled even while the
// output is stalled; the input stalls only when every cell holds a word. Write the registers
// only while no word is in flight.
`include "modulus_encoder_six_digit_top_assert.svh"

module modulus_encoder_six_digit_top #(
  parameter int MAX_FRAME_BITS = mes6_pkg::DEFAULT_MAX_FRAME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mes6_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mes6_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [MAX_FRAME_BITS-1:0]       in_frame_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mes6_pkg::DIGIT_W-1:0]    out_digit0,
  output logic [mes6_pkg::DIGIT_W-1:0]    out_digit1,
  output logic [mes6_pkg::DIGIT_W-1:0]    out_digit2,
  output logic [mes6_pkg::DIGIT_W-1:0]    out_digit3,
  output logic [mes6_pkg::DIGIT_W-1:0]    out_digit4,
  output logic [mes6_pkg::DIGIT5_W-1:0]   out_digit5
);
  import mes6_pkg::*;

  localparam int NCELL = (MAX_FRAME_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DW    = NCELL * STEP_BITS;
  localparam int NST   = NUM_MODULI * NCELL;

  cfg_t                  cfg;
  logic [COUNT_W-1:0]    n_bits;
  logic [MAX_FRAME_BITS-1:0] mask;

  logic                valid_s  [0:NST];
  logic [DW-1:0]       work_s   [0:NST];
  logic [DIGIT_W-1:0]  rem_s    [0:NST];
  digits_t             digits_s [0:NST];
  logic                adv      [1:NST];

  mes6_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    n_bits = cfg.bit_count;
    if (int'(cfg.bit_count) > MAX_FRAME_BITS) begin
      n_bits = COUNT_W'(MAX_FRAME_BITS);
    end
    for (int j = 0; j < MAX_FRAME_BITS; j++) begin
      mask[j] = (j < int'(n_bits));
    end
  end

  assign valid_s[0]  = in_valid;
  assign work_s[0]   = DW'(in_frame_bits & mask);
  assign rem_s[0]    = '0;
  assign digits_s[0] = '0;

  assign adv[NST] = !valid_s[NST] || !out_stall;

  genvar gd, gc;
  generate
    for (gd = 0; gd < NUM_MODULI; gd++) begin : g_div
      for (gc = 0; gc < NCELL; gc++) begin : g_cell
        localparam int IDX = gd * NCELL + gc + 1;

        if (IDX < NST) begin : g_adv
          assign adv[IDX] = !valid_s[IDX] || adv[IDX+1];
        end

        mes6_cell #(
          .DW        (DW),
          .STEPS     (STEP_BITS),
          .DIGIT_IDX (gd),
          .LAST      (gc == NCELL - 1)
        ) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .adv        (adv[IDX]),
          .in_valid   (valid_s[IDX-1]),
          .in_work    (work_s[IDX-1]),
          .in_rem     (rem_s[IDX-1]),
          .in_digits  (digits_s[IDX-1]),
          .modulus    (cfg.moduli[gd]),
          .out_valid  (valid_s[IDX]),
          .out_work   (work_s[IDX]),
          .out_rem    (rem_s[IDX]),
          .out_digits (digits_s[IDX])
        );
      end
    end
  endgenerate

  assign in_stall   = !adv[1];
  assign out_valid  = valid_s[NST];
  assign out_digit0 = digits_s[NST][0];
  assign out_digit1 = digits_s[NST][1];
  assign out_digit2 = digits_s[NST][2];
  assign out_digit3 = digits_s[NST][3];
  assign out_digit4 = digits_s[NST][4];
  assign out_digit5 = DIGIT5_W'(work_s[NST]);

  `MES6_ASSERT_NXT(a_accept_fills_first, clk, rst_n, in_valid && !in_stall, valid_s[1])
  `MES6_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall)
  `MES6_ASSERT_NXT(a_mid_word_held, clk, rst_n, valid_s[NST/2] && !adv[NST/2], valid_s[NST/2])

endmodule

### rtl/mes6_cfg.sv
`timescale 1ns / 1ps

module mes6_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mes6_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mes6_pkg::CFG_DATA_W-1:0] cfg_data,
  output mes6_pkg::cfg_t                  cfg
);
  import mes6_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_BIT_COUNT: begin
          cfg_nxt.bit_count = cfg_data[COUNT_W-1:0];
        end
        default: begin
          for (int k = 0; k < NUM_MODULI; k++) begin
            if (cfg_index == CFG_MODULUS_0 + CFG_IDX_W'(k)) begin
              cfg_nxt.moduli[k] = clamp_modulus(cfg_data[MOD_W-1:0]);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count <= '0;
      for (int k = 0; k < NUM_MODULI; k++) begin
        cfg_r.moduli[k] <= MOD_MIN;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/mes6_cell.sv
`timescale 1ns / 1ps

module mes6_cell #(
  parameter int DW        = 64,
  parameter int STEPS     = 8,
  parameter int DIGIT_IDX = 0,
  parameter bit LAST      = 1'b0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [DW-1:0]                in_work,
  input  logic [mes6_pkg::DIGIT_W-1:0] in_rem,
  input  mes6_pkg::digits_t            in_digits,
  input  logic [mes6_pkg::MOD_W-1:0]   modulus,
  output logic                         out_valid,
  output logic [DW-1:0]                out_work,
  output logic [mes6_pkg::DIGIT_W-1:0] out_rem,
  output mes6_pkg::digits_t            out_digits
);
  import mes6_pkg::*;

  logic                valid_r;
  logic [DW-1:0]       work_r;
  logic [DW-1:0]       work_nxt;
  logic [DIGIT_W-1:0]  rem_r;
  logic [DIGIT_W-1:0]  rem_nxt;
  digits_t             digits_r;
  digits_t             digits_nxt;
  logic [MOD_W-1:0]    trial;
  logic [DIGIT_W-1:0]  rem;

  // Restoring long division, one quotient bit per step, dividend MSB first.
  always_comb begin
    rem      = in_rem;
    work_nxt = in_work;
    trial    = '0;
    for (int s = 0; s < STEPS; s++) begin
      trial    = {rem, work_nxt[DW-1]};
      work_nxt = {work_nxt[DW-2:0], 1'b0};
      if (trial >= modulus) begin
        trial       = trial - modulus;
        work_nxt[0] = 1'b1;
      end
      rem = trial[DIGIT_W-1:0];
    end
    digits_nxt = in_digits;
    rem_nxt    = rem;
    if (LAST) begin
      digits_nxt[DIGIT_IDX] = rem;
      rem_nxt               = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      work_r   <= work_nxt;
      rem_r    <= rem_nxt;
      digits_r <= digits_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_work   = work_r;
  assign out_rem    = rem_r;
  assign out_digits = digits_r;

endmodule
